// ===== hdl/qvr_pkg.sv =====
// Shared types and constants for the quaternion vector rotation block.
// No dependencies; imported by qvr_coef, qvr_div_stage, the top level and the testbench.
package qvr_pkg;

   // Quaternion register format (signed Q1.14)
   localparam int QUAT_W = 16;
   localparam logic signed [QUAT_W-1:0] QUAT_W_RESET = 16'sd16384;

   // Width of one rotation matrix coefficient and of the divisor 2n
   localparam int COEF_W = 34;

   // Register index decode
   localparam int CSR_IDX_W = 4;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_QUAT_X = 4'd0,
      CSR_QUAT_Y = 4'd1,
      CSR_QUAT_Z = 4'd2,
      CSR_QUAT_W = 4'd3
   } csr_idx_type;

   // Matrix, norm and zero flag derived from the quaternion registers
   typedef struct packed {
      logic [2:0][2:0][COEF_W-1:0] mat;
      logic [COEF_W-1:0]           norm;
      logic [COEF_W-1:0]           div;
      logic                        zero;
   } coef_type;

endpackage

// ===== hdl/qvr_coef.sv =====
// Rotation matrix and norm from the quaternion registers, two register stages.
// Depends on qvr_pkg.
module qvr_coef (
   input  logic                                  clock,
   input  logic signed [qvr_pkg::QUAT_W-1:0]     quat_x,
   input  logic signed [qvr_pkg::QUAT_W-1:0]     quat_y,
   input  logic signed [qvr_pkg::QUAT_W-1:0]     quat_z,
   input  logic signed [qvr_pkg::QUAT_W-1:0]     quat_w,
   output qvr_pkg::coef_type                     coef
);
   import qvr_pkg::*;

   logic signed [31:0] xx_ff, yy_ff, zz_ff, ww_ff;
   logic signed [31:0] xy_ff, xz_ff, yz_ff, wx_ff, wy_ff, wz_ff;
   logic signed [COEF_W-1:0] xx, yy, zz, ww, xy, xz, yz, wx, wy, wz;
   logic signed [COEF_W-1:0] nrm;
   coef_type coef_in, coef_ff;

   // Form squares and cross products
   always_ff @(posedge clock) begin
      xx_ff <= quat_x * quat_x;
      yy_ff <= quat_y * quat_y;
      zz_ff <= quat_z * quat_z;
      ww_ff <= quat_w * quat_w;
      xy_ff <= quat_x * quat_y;
      xz_ff <= quat_x * quat_z;
      yz_ff <= quat_y * quat_z;
      wx_ff <= quat_w * quat_x;
      wy_ff <= quat_w * quat_y;
      wz_ff <= quat_w * quat_z;
   end

   // Combine into matrix entries and norm
   always_comb begin
      xx = COEF_W'(xx_ff);
      yy = COEF_W'(yy_ff);
      zz = COEF_W'(zz_ff);
      ww = COEF_W'(ww_ff);
      xy = COEF_W'(xy_ff);
      xz = COEF_W'(xz_ff);
      yz = COEF_W'(yz_ff);
      wx = COEF_W'(wx_ff);
      wy = COEF_W'(wy_ff);
      wz = COEF_W'(wz_ff);
      nrm = ww + xx + yy + zz;
      coef_in.mat[0][0] = ww + xx - yy - zz;
      coef_in.mat[0][1] = (xy - wz) <<< 1;
      coef_in.mat[0][2] = (xz + wy) <<< 1;
      coef_in.mat[1][0] = (xy + wz) <<< 1;
      coef_in.mat[1][1] = ww - xx + yy - zz;
      coef_in.mat[1][2] = (yz - wx) <<< 1;
      coef_in.mat[2][0] = (xz - wy) <<< 1;
      coef_in.mat[2][1] = (yz + wx) <<< 1;
      coef_in.mat[2][2] = ww - xx - yy + zz;
      coef_in.norm = nrm;
      coef_in.div  = nrm << 1;
      coef_in.zero = (nrm == '0);
   end

   always_ff @(posedge clock) begin
      coef_ff <= coef_in;
   end

   assign coef = coef_ff;

endmodule

// ===== hdl/qvr_div_stage.sv =====
// One restoring division stage: one quotient bit for each of three lanes.
// Depends on qvr_pkg.
module qvr_div_stage #(
   parameter int RW    = 54,
   parameter int QW    = 17,
   parameter int SHIFT = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic                         valid_in,
   input  logic [RW-1:0]                rem_in [3],
   input  logic [QW-1:0]                quo_in [3],
   input  logic [qvr_pkg::COEF_W-1:0]   div,
   output logic                         valid_out,
   output logic [RW-1:0]                rem_out [3],
   output logic [QW-1:0]                quo_out [3]
);
   import qvr_pkg::*;

   logic [RW-1:0] dsh;
   logic [RW-1:0] rem_in_c [3];
   logic [QW-1:0] quo_in_c [3];
   logic [RW-1:0] rem_ff [3];
   logic [QW-1:0] quo_ff [3];
   logic          vld_ff;

   assign dsh = RW'(div) << SHIFT;

   // Compare and subtract the shifted divisor
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (rem_in[i] >= dsh) begin
            rem_in_c[i] = rem_in[i] - dsh;
            quo_in_c[i] = {quo_in[i][QW-2:0], 1'b1};
         end else begin
            rem_in_c[i] = rem_in[i];
            quo_in_c[i] = {quo_in[i][QW-2:0], 1'b0};
         end
      end
   end

   // Advance when the next stage frees up
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff <= rem_in_c;
         quo_ff <= quo_in_c;
      end
   end

   assign valid_out = vld_ff;
   assign rem_out   = rem_ff;
   assign quo_out   = quo_ff;

endmodule

// ===== hdl/quaternion_vector_rotation.sv =====
// Quaternion vector rotation: r = vector part of q*(v,0)*conj(q)/|q|^2.
// Takes one word per cycle while the result side is not stalled.
// Depth is set by the divider, one quotient bit per stage over VEC_WIDTH+1 stages.
// Stages advance independently, so bubbles close up behind a stalled result.
// Synchronous reset clears valid bits and loads the identity quaternion.
// Depends on qvr_pkg, qvr_coef, qvr_div_stage.
module quaternion_vector_rotation #(
   parameter int VEC_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [VEC_WIDTH-1:0]         req_vec_x,
   input  logic signed [VEC_WIDTH-1:0]         req_vec_y,
   input  logic signed [VEC_WIDTH-1:0]         req_vec_z,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [VEC_WIDTH-1:0]         rsp_rot_x,
   output logic signed [VEC_WIDTH-1:0]         rsp_rot_y,
   output logic signed [VEC_WIDTH-1:0]         rsp_rot_z,
   output logic                                rsp_zero_quat,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [qvr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [qvr_pkg::QUAT_W-1:0]          csr_wdata
);
   import qvr_pkg::*;

   localparam int VW = VEC_WIDTH;
   localparam int PW = VW + COEF_W;
   localparam int RW = VW + COEF_W + 4;
   localparam int QW = VW + 1;
   localparam int NPRE = 5;
   localparam int NS = NPRE + QW + 1;
   localparam int OS = NS - 1;
   localparam logic signed [QW:0] Q_BIAS = (QW+1)'(1) << VW;
   localparam logic signed [QW:0] SAT_HI = ((QW+1)'(1) << (VW - 1)) - (QW+1)'(1);
   localparam logic signed [QW:0] SAT_LO = -SAT_HI - (QW+1)'(1);

   logic signed [QUAT_W-1:0] quat_x_ff, quat_y_ff, quat_z_ff, quat_w_ff;
   coef_type coef;

   logic [NS-1:0] stage_vld;
   logic [NS-1:0] adv;
   logic [NPRE-1:0] pre_vld_ff;

   logic signed [VW-1:0] vec0_ff [3];
   logic signed [VW-1:0] vec1_ff [3];
   logic signed [VW-1:0] vec2_ff [3];
   logic signed [PW-1:0] prod_in [3][3];
   logic signed [PW-1:0] prod_ff [3][3];
   logic [RW-1:0] num_in [3];
   logic [RW-1:0] num_ff [3];

   logic [RW-1:0] rem_w [QW+1][3];
   logic [QW-1:0] quo_w [QW+1][3];
   logic          vld_w [QW+1];

   logic signed [QW:0] qs [3];
   logic signed [VW-1:0] rot_in [3];
   logic signed [VW-1:0] rot_ff [3];
   logic rsp_valid_ff, zero_ff;

   // Configuration registers, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         quat_x_ff <= '0;
         quat_y_ff <= '0;
         quat_z_ff <= '0;
         quat_w_ff <= QUAT_W_RESET;
      end else if (csr_valid) begin
         unique case (csr_idx_type'(csr_index))
            CSR_QUAT_X: quat_x_ff <= csr_wdata;
            CSR_QUAT_Y: quat_y_ff <= csr_wdata;
            CSR_QUAT_Z: quat_z_ff <= csr_wdata;
            CSR_QUAT_W: quat_w_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   qvr_coef u_coef (
      .clock  (clock),
      .quat_x (quat_x_ff),
      .quat_y (quat_y_ff),
      .quat_z (quat_z_ff),
      .quat_w (quat_w_ff),
      .coef   (coef)
   );

   // Advance each stage when it is empty or its successor advances
   always_comb begin
      stage_vld[NPRE-1:0] = pre_vld_ff;
      for (int s = 0; s < QW; s++) begin
         stage_vld[NPRE+s] = vld_w[s+1];
      end
      stage_vld[OS] = rsp_valid_ff;
      adv[OS] = !rsp_valid_ff || !rsp_stall;
      for (int s = OS - 1; s >= 0; s--) begin
         adv[s] = !stage_vld[s] || adv[s+1];
      end
   end

   assign req_stall = !adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_vld_ff <= '0;
      end else begin
         if (adv[0]) pre_vld_ff[0] <= req_valid;
         for (int s = 1; s < NPRE; s++) begin
            if (adv[s]) pre_vld_ff[s] <= pre_vld_ff[s-1];
         end
      end
   end

   // Hold the vector while the derived coefficients settle
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         vec0_ff[0] <= req_vec_x;
         vec0_ff[1] <= req_vec_y;
         vec0_ff[2] <= req_vec_z;
      end
      if (adv[1]) vec1_ff <= vec0_ff;
      if (adv[2]) vec2_ff <= vec1_ff;
   end

   // Matrix times vector products
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod_in[i][j] = PW'($signed(coef.mat[i][j])) * PW'(vec2_ff[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[3]) prod_ff <= prod_in;
   end

   // Dividend 2S + n, biased by 2n * 2^VW to stay nonnegative
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num_in[i] = ((RW'(prod_ff[i][0]) + RW'(prod_ff[i][1]) + RW'(prod_ff[i][2])) << 1)
                     + RW'(coef.norm) + (RW'(coef.div) << VW);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[4]) num_ff <= num_in;
   end

   // Restoring divider, most significant quotient bit first
   always_comb begin
      rem_w[0] = num_ff;
      for (int i = 0; i < 3; i++) begin
         quo_w[0][i] = '0;
      end
      vld_w[0] = pre_vld_ff[NPRE-1];
   end

   for (genvar s = 0; s < QW; s++) begin : g_div
      qvr_div_stage #(
         .RW    (RW),
         .QW    (QW),
         .SHIFT (QW - 1 - s)
      ) u_div (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv[NPRE+s]),
         .valid_in  (vld_w[s]),
         .rem_in    (rem_w[s]),
         .quo_in    (quo_w[s]),
         .div       (coef.div),
         .valid_out (vld_w[s+1]),
         .rem_out   (rem_w[s+1]),
         .quo_out   (quo_w[s+1])
      );
   end

   // Remove the bias, saturate, force zero for a null quaternion
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         qs[i] = $signed({1'b0, quo_w[QW][i]}) - Q_BIAS;
         if (coef.zero) begin
            rot_in[i] = '0;
         end else if (qs[i] > SAT_HI) begin
            rot_in[i] = SAT_HI[VW-1:0];
         end else if (qs[i] < SAT_LO) begin
            rot_in[i] = SAT_LO[VW-1:0];
         end else begin
            rot_in[i] = qs[i][VW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv[OS]) begin
         rsp_valid_ff <= vld_w[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[OS]) begin
         rot_ff  <= rot_in;
         zero_ff <= coef.zero;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_rot_x     = rot_ff[0];
   assign rsp_rot_y     = rot_ff[1];
   assign rsp_rot_z     = rot_ff[2];
   assign rsp_zero_quat = zero_ff;

endmodule

// ===== hdl/qvr_checker.sv =====
// Port-level checks for quaternion_vector_rotation, bound to the top level.
// Depends only on the top level's port list.
module qvr_checker #(
   parameter int VEC_WIDTH = 16
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic signed [VEC_WIDTH-1:0]   rsp_rot_x,
   input logic signed [VEC_WIDTH-1:0]   rsp_rot_y,
   input logic signed [VEC_WIDTH-1:0]   rsp_rot_z,
   input logic                          rsp_zero_quat
);

   // Drop all results on reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   // Input backs up only when the result side is stalled
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a stalled result");

   // Null quaternion gives a zero vector
   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_zero_quat) |->
         (rsp_rot_x == '0 && rsp_rot_y == '0 && rsp_rot_z == '0))
      else $error("nonzero result with zero quaternion");

   // Hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_rot_x)
         && $stable(rsp_rot_y) && $stable(rsp_rot_z) && $stable(rsp_zero_quat)))
      else $error("stalled result word changed");

endmodule

bind quaternion_vector_rotation qvr_checker #(.VEC_WIDTH(VEC_WIDTH)) u_qvr_checker (.*);

// ===== dv/quaternion_vector_rotation_tb.sv =====
// Self-checking testbench for the quaternion vector rotation block.
// Drives vector words and quaternion register writes, predicts each rotated word.
// Depends on qvr_pkg and the quaternion_vector_rotation RTL.
module quaternion_vector_rotation_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import qvr_pkg::*;

   localparam int VW = 16;
   localparam int PIPE_LAT = VW + 6;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic signed [VW-1:0] rx;
      logic signed [VW-1:0] ry;
      logic signed [VW-1:0] rz;
      logic                 zq;
   } rot_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [VW-1:0] req_vec_x = '0;
   logic signed [VW-1:0] req_vec_y = '0;
   logic signed [VW-1:0] req_vec_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [VW-1:0] rsp_rot_x;
   logic signed [VW-1:0] rsp_rot_y;
   logic signed [VW-1:0] rsp_rot_z;
   logic rsp_zero_quat;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [QUAT_W-1:0] csr_wdata = '0;

   // quaternion copy held by the predictor
   logic signed [QUAT_W-1:0] q_x, q_y, q_z, q_w;

   rot_word_type rot_expected[$];
   int  mismatches = 0;
   int  words_checked = 0;
   int  words_sent = 0;
   longint cycles = 0;
   int  hold_cycles = 0;   // forced receiver hold-off length
   bit  stall_random = 1'b1;

   quaternion_vector_rotation #(.VEC_WIDTH(VW)) u_top (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // round(num/n) ties up, then clamp
   function automatic logic signed [VW-1:0] round_sat(input longint num, input longint n);
      longint d, fq;
      d = 2 * num + n;
      fq = d / (2 * n);
      if ((d % (2 * n)) != 0 && d < 0) fq--;
      if (fq > 32767) fq = 32767;
      if (fq < -32768) fq = -32768;
      return fq[VW-1:0];
   endfunction

   function automatic rot_word_type rotate_vec(input logic signed [VW-1:0] vx,
                                               input logic signed [VW-1:0] vy,
                                               input logic signed [VW-1:0] vz);
      longint x, y, z, w, n, a, b, c;
      rot_word_type r;
      x = q_x; y = q_y; z = q_z; w = q_w;
      n = w*w + x*x + y*y + z*z;
      r = '0;
      if (n == 0) begin
         r.zq = 1'b1;
         return r;
      end
      // products stay well inside 64 bits: |M| < 2^33, |v| <= 2^15
      a = (w*w + x*x - y*y - z*z) * vx + 2*(x*y - w*z) * vy + 2*(x*z + w*y) * vz;
      b = 2*(x*y + w*z) * vx + (w*w - x*x + y*y - z*z) * vy + 2*(y*z - w*x) * vz;
      c = 2*(x*z - w*y) * vx + 2*(y*z + w*x) * vy + (w*w - x*x - y*y + z*z) * vz;
      r.rx = round_sat(a, n);
      r.ry = round_sat(b, n);
      r.rz = round_sat(c, n);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("[%0d] mismatch word %0d %s: got %0d want %0d",
               cycles, words_checked, what, got, want);
      mismatches++;
   endtask

   // check each accepted result word
   always @(posedge clock) begin
      rot_word_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rot_expected.size() == 0) begin
            report_mismatch("unexpected", 0, 0);
         end else begin
            e = rot_expected.pop_front();
            if (rsp_rot_x !== e.rx) report_mismatch("rot_x", rsp_rot_x, e.rx);
            if (rsp_rot_y !== e.ry) report_mismatch("rot_y", rsp_rot_y, e.ry);
            if (rsp_rot_z !== e.rz) report_mismatch("rot_z", rsp_rot_z, e.rz);
            if (rsp_zero_quat !== e.zq) report_mismatch("zero_quat", rsp_zero_quat, e.zq);
         end
         words_checked++;
      end
   end

   // receiver stall: random gaps, or a forced hold-off counted here
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else if (stall_random && $urandom_range(0, 3) == 0) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // idle wait so that valid drops between words
   task automatic idle_gap(input bit allow);
      int n;
      if (!allow) return;
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 2);
      repeat (n) @(posedge clock);
   endtask

   // offer one vector word and hold it until accepted
   task automatic send_vec(input logic [VW-1:0] vx, input logic [VW-1:0] vy,
                           input logic [VW-1:0] vz, input bit gaps);
      req_valid <= 1'b1;
      req_vec_x <= vx;
      req_vec_y <= vy;
      req_vec_z <= vz;
      do @(posedge clock); while (req_stall);
      rot_expected.push_back(rotate_vec(vx, vy, vz));
      words_sent++;
      if (gaps && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         idle_gap(1);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (rot_expected.size() != 0) @(posedge clock);
      repeat (PIPE_LAT + 4) @(posedge clock);
   endtask

   // offer one register word; set_quat drops valid after the last one
   task automatic write_quat(input csr_idx_type idx, input logic [QUAT_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_QUAT_X: q_x = val;
         CSR_QUAT_Y: q_y = val;
         CSR_QUAT_Z: q_z = val;
         CSR_QUAT_W: q_w = val;
         default: ;
      endcase
   endtask

   task automatic set_quat(input logic [15:0] x, input logic [15:0] y,
                           input logic [15:0] z, input logic [15:0] w);
      write_quat(CSR_QUAT_X, x);
      write_quat(CSR_QUAT_Y, y);
      write_quat(CSR_QUAT_Z, z);
      write_quat(CSR_QUAT_W, w);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [VW-1:0] rand_comp();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return VW'($urandom_range(0, 15) - 8);
         default: return VW'($urandom);
      endcase
   endfunction

   // extremes under the reset identity quaternion
   task automatic test_identity_extremes();
      logic [VW-1:0] ext[6] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001, 16'h5555};
      foreach (ext[i]) send_vec(ext[i], ext[(i+1)%6], ext[(i+2)%6], 1'b0);
      drain();
   endtask

   // zero quaternion forces zero and the flag; large q saturates; small q rounds
   task automatic test_special_quats();
      set_quat(0, 0, 0, 0);
      send_vec(16'h7fff, 16'h8000, 16'h1234, 1'b0);
      send_vec(0, 0, 0, 1'b0);
      drain();
      // 45 deg about z: a diagonal vector's y component grows past range
      set_quat(0, 0, 16'd6270, 16'd15137);
      send_vec(16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
      send_vec(16'h8000, 16'h8000, 16'h8000, 1'b0);
      drain();
      // extremes of the registers, non-unit length
      set_quat(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
      send_vec(16'h7fff, 16'h8000, 16'h0001, 1'b0);
      send_vec(16'h0003, 16'hfffd, 16'h0001, 1'b0);
      drain();
      // x = 2, w = 2: n = 8, a quarter turn about x with a tiny quaternion
      set_quat(16'd2, 0, 0, 16'd2);
      for (int i = -3; i <= 3; i++) send_vec(VW'(i), VW'(i + 1), VW'(-i), 1'b0);
      drain();
   endtask

   // random quaternions, random vectors, random gaps on both sides
   task automatic test_random(input int phases, input int per_phase);
      for (int p = 0; p < phases; p++) begin
         if (p == phases - 1) set_quat(0, 0, 0, 0);
         else if (p % 4 == 0) set_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
         else set_quat(QUAT_W'($urandom_range(0, 64) - 32), QUAT_W'($urandom),
                       QUAT_W'($urandom), QUAT_W'($urandom));
         for (int i = 0; i < per_phase; i++) send_vec(rand_comp(), rand_comp(), rand_comp(), 1'b1);
         drain();
      end
   endtask

   // receiver holds off while the sender keeps offering words
   task automatic test_backpressure();
      set_quat(QUAT_W'($urandom), QUAT_W'($urandom), QUAT_W'($urandom), 16'd16384);
      hold_cycles <= 200;
      for (int i = 0; i < 60; i++) send_vec(rand_comp(), rand_comp(), rand_comp(), 1'b0);
      drain();
      stall_random = 1'b0;
      for (int i = 0; i < 40; i++) send_vec(VW'($urandom), VW'($urandom), VW'($urandom), 1'b0);
      drain();
      stall_random = 1'b1;
   endtask

   initial begin
      q_x = 0; q_y = 0; q_z = 0; q_w = QUAT_W_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_identity_extremes();
      test_special_quats();
      test_backpressure();
      test_random(12, 50);
      drain();
      $display("Sent %0d vector words, checked %0d, across register extremes,", words_sent,
               words_checked);
      $display("zero quaternion, saturation, rounding and long output hold-off.");
      if (mismatches == 0 && rot_expected.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
